### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Both macros expect clk in scope;
// ASSERT_CLK also expects rst_n. Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check at every clock edge once reset is released.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)
`endif

`endif

### sv/mpwc_pkg.sv
// ----------------------------------------------------------------------------
// mpwc_pkg
// Shared constants and types of the multichannel pulse width capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpwc_pkg;

    localparam int CHANNELS     = 6;
    localparam int PIN_COUNT    = 6;
    localparam int ACTIVE_LANES = (CHANNELS < PIN_COUNT) ? CHANNELS : PIN_COUNT;

    localparam int STAMP_W   = 16;
    localparam int TICK_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [TICK_W-1:0]  tick_t;

    localparam tick_t  TICK_US_RST   = 8'd8;
    localparam stamp_t MIN_WIDTH_RST = 16'd1000;
    localparam stamp_t MAX_WIDTH_RST = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_US   = 2'd0,
        CFG_MIN_WIDTH = 2'd1,
        CFG_MAX_WIDTH = 2'd2
    } cfg_idx_e;

    // Edge events handed to one lane for the current beat.
    typedef struct packed {
        logic rise;
        logic fall;
    } lane_ctrl_t;

    // What one lane reports for the current beat.
    typedef struct packed {
        stamp_t width;
        logic   closed;
        logic   accepted;
    } lane_res_t;

    // One complete result beat.
    typedef struct packed {
        logic [PIN_COUNT-1:0][STAMP_W-1:0] widths;
        logic [PIN_COUNT-1:0]              closed;
        logic [PIN_COUNT-1:0]              accepted;
    } result_t;

endpackage

`default_nettype wire

### sv/mpwc_lane.sv
// ----------------------------------------------------------------------------
// mpwc_lane
// One capture channel: start stamp, high flag and last accepted width.
// ----------------------------------------------------------------------------
`default_nettype none

module mpwc_lane (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mpwc_pkg::lane_ctrl_t ctrl,
    input  wire mpwc_pkg::stamp_t    now_stamp,
    input  wire mpwc_pkg::stamp_t    min_width,
    input  wire mpwc_pkg::stamp_t    max_width,
    output mpwc_pkg::lane_res_t      res
);
    import mpwc_pkg::*;

    logic   high_reg, high_next;
    stamp_t start_reg, start_next;
    stamp_t width_reg, width_next;
    stamp_t span;
    logic   close_now;
    logic   keep_now;

    always_comb
    begin
        span      = now_stamp - start_reg;
        close_now = ctrl.fall & high_reg;
        keep_now  = close_now & (span > min_width) & (span < max_width);

        high_next  = high_reg;
        start_next = start_reg;
        width_next = width_reg;
        if (ctrl.rise)
        begin
            high_next  = 1'b1;
            start_next = now_stamp;
        end
        else if (close_now)
        begin
            high_next = 1'b0;
        end
        if (keep_now)
        begin
            width_next = span;
        end

        res.width    = width_next;
        res.closed   = close_now;
        res.accepted = keep_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg  <= 1'b0;
            start_reg <= '0;
            width_reg <= '0;
        end
        else
        begin
            high_reg  <= high_next;
            start_reg <= start_next;
            width_reg <= width_next;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_CLK(a_rise_loads_stamp, ctrl.rise |=> high_reg && (start_reg == $past(now_stamp)))
    `ASSERT_CLK(a_width_only_on_fall, !ctrl.fall |=> $stable(width_reg))

endmodule

`default_nettype wire

### sv/mpwc_merge.sv
// ----------------------------------------------------------------------------
// mpwc_merge
// Buffer the gathered lane result beats: output register plus skid slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mpwc_merge (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mpwc_pkg::result_t res_in,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output mpwc_pkg::result_t      res_out
);
    import mpwc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    pop;
    logic    out_free;

    always_comb
    begin
        pop      = out_valid_reg & out_ready;
        out_free = ~out_valid_reg | pop;

        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // Advance the skid beat; the new beat, if any, takes its slot.
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = res_in;
            end
            else
            begin
                out_valid_next = push;
                out_next       = res_in;
            end
        end
        else if (push)
        begin
            // Output held: park the new beat in the skid slot.
            skid_valid_next = 1'b1;
            skid_next       = res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign res_out   = out_reg;

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `ASSERT_CLK(a_no_drop, push && out_valid_reg && !out_ready |=> skid_valid_reg)

endmodule

`default_nettype wire

### sv/multichannel_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// multichannel_pulse_width_capture
// Six-channel RC PWM pulse width capture: edge detection on sampled pins,
// per-channel start stamps, bounded width acceptance.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | sink      | in_valid / in_ready  | pin_levels
//  out     | source    | out_valid / out_ready| width_ch0..5, closed_mask,
//          |           |                      | accepted_mask
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready holds: every lane finishes
// its edge work in the cycle the beat is accepted; the result is registered.
// The output register plus one skid slot keeps in_ready high while one
// result waits; in_ready drops only when both are full.
// Reset clears stamps, widths, flags and restores register defaults.
// cfg_ready is always high; writes are meant to land while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_pulse_width_capture (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // sample beats
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [mpwc_pkg::PIN_COUNT-1:0]     pin_levels,
    // result beats
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [mpwc_pkg::STAMP_W-1:0]            width_ch0,
    output logic [mpwc_pkg::STAMP_W-1:0]            width_ch1,
    output logic [mpwc_pkg::STAMP_W-1:0]            width_ch2,
    output logic [mpwc_pkg::STAMP_W-1:0]            width_ch3,
    output logic [mpwc_pkg::STAMP_W-1:0]            width_ch4,
    output logic [mpwc_pkg::STAMP_W-1:0]            width_ch5,
    output logic [mpwc_pkg::PIN_COUNT-1:0]          closed_mask,
    output logic [mpwc_pkg::PIN_COUNT-1:0]          accepted_mask,
    // register writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mpwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mpwc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mpwc_pkg::*;

    // Configuration registers
    tick_t  tick_us_reg, tick_us_next;
    stamp_t min_width_reg, min_width_next;
    stamp_t max_width_reg, max_width_next;

    // Shared timing state
    logic [PIN_COUNT-1:0] prev_levels_reg, prev_levels_next;
    stamp_t               now_stamp_reg, now_stamp_next;

    logic                 fire;
    logic [PIN_COUNT-1:0] changed;
    lane_ctrl_t           lane_ctrl [PIN_COUNT];
    lane_res_t            lane_res  [PIN_COUNT];
    result_t              res_new;
    result_t              res_out;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid & in_ready;
    assign changed   = pin_levels ^ prev_levels_reg;

    // Register writes; an index past the list is dropped.
    always_comb
    begin
        tick_us_next   = tick_us_reg;
        min_width_next = min_width_reg;
        max_width_next = max_width_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_TICK_US:   tick_us_next   = cfg_data[TICK_W-1:0];
                CFG_MIN_WIDTH: min_width_next = cfg_data[STAMP_W-1:0];
                CFG_MAX_WIDTH: max_width_next = cfg_data[STAMP_W-1:0];
                default:       ;
            endcase
        end
    end

    // Advance the timestamp and hold the sample only on an accepted beat.
    always_comb
    begin
        prev_levels_next = prev_levels_reg;
        now_stamp_next   = now_stamp_reg;
        if (fire)
        begin
            prev_levels_next = pin_levels;
            now_stamp_next   = now_stamp_reg + {{(STAMP_W-TICK_W){1'b0}}, tick_us_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_us_reg     <= TICK_US_RST;
            min_width_reg   <= MIN_WIDTH_RST;
            max_width_reg   <= MAX_WIDTH_RST;
            prev_levels_reg <= '0;
            now_stamp_reg   <= '0;
        end
        else
        begin
            tick_us_reg     <= tick_us_next;
            min_width_reg   <= min_width_next;
            max_width_reg   <= max_width_next;
            prev_levels_reg <= prev_levels_next;
            now_stamp_reg   <= now_stamp_next;
        end
    end

    // One lane per active channel; pins past the active count read zero.
    for (genvar i = 0; i < PIN_COUNT; i++)
    begin : g_lane
        if (i < ACTIVE_LANES)
        begin : g_on
            always_comb
            begin
                lane_ctrl[i].rise = fire & changed[i] & ~prev_levels_reg[i];
                lane_ctrl[i].fall = fire & changed[i] &  prev_levels_reg[i];
            end

            mpwc_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (lane_ctrl[i]),
                .now_stamp (now_stamp_reg),
                .min_width (min_width_reg),
                .max_width (max_width_reg),
                .res       (lane_res[i])
            );
        end
        else
        begin : g_off
            always_comb
            begin
                lane_ctrl[i] = '0;
                lane_res[i]  = '0;
            end
        end

        always_comb
        begin
            res_new.widths[i]   = lane_res[i].width;
            res_new.closed[i]   = lane_res[i].closed;
            res_new.accepted[i] = lane_res[i].accepted;
        end
    end

    mpwc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .res_in    (res_new),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign width_ch0     = res_out.widths[0];
    assign width_ch1     = res_out.widths[1];
    assign width_ch2     = res_out.widths[2];
    assign width_ch3     = res_out.widths[3];
    assign width_ch4     = res_out.widths[4];
    assign width_ch5     = res_out.widths[5];
    assign closed_mask   = res_out.closed;
    assign accepted_mask = res_out.accepted;

endmodule

`default_nettype wire

### test/tb_multichannel_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// tb_multichannel_pulse_width_capture
// Sends pin sample beats through the capture block and checks every result
// beat against a cycle-free model of edge stamping and bounded width acceptance,
// or a hand-typed result. A short directed table runs first, then pulse trains
// with random content under several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_multichannel_pulse_width_capture;
    timeunit 1ns;
    timeprecision 1ps;

    import mpwc_pkg::*;

    // Quiet cycles tolerated before the run is declared hung.
    localparam int STALL_LIMIT   = 5000;
    // Cycles to hold off after the last result before touching registers.
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 6;
    localparam int PHASE_BEATS   = 140;
    // Index outside the register map: writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] NO_SUCH_REG = 2'd3;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [PIN_COUNT-1:0]  pin_levels    = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [STAMP_W-1:0]    width_ch0, width_ch1, width_ch2;
    logic [STAMP_W-1:0]    width_ch3, width_ch4, width_ch5;
    logic [PIN_COUNT-1:0]  closed_mask;
    logic [PIN_COUNT-1:0]  accepted_mask;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    multichannel_pulse_width_capture DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pin_levels    (pin_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .width_ch0     (width_ch0),
        .width_ch1     (width_ch1),
        .width_ch2     (width_ch2),
        .width_ch3     (width_ch3),
        .width_ch4     (width_ch4),
        .width_ch5     (width_ch5),
        .closed_mask   (closed_mask),
        .accepted_mask (accepted_mask),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Model state: register copies plus per-channel capture state, all at
    // the block's own widths so wraparound falls out of the arithmetic.
    // ------------------------------------------------------------------------
    tick_t                cfg_tick  = TICK_US_RST;
    stamp_t               cfg_min   = MIN_WIDTH_RST;
    stamp_t               cfg_max   = MAX_WIDTH_RST;
    logic [PIN_COUNT-1:0] prev_lv   = '0;
    logic                 lane_high [PIN_COUNT];
    stamp_t               rise_st   [PIN_COUNT];
    stamp_t               held_w    [PIN_COUNT];
    stamp_t               now_st    = '0;

    result_t pending_q [$];     // expected result beats, oldest first
    int      mismatches    = 0;
    int      send_idle_pct = 0; // chance per cycle that the sender holds off
    int      recv_stall_pct = 0; // chance per cycle that the receiver stalls

    // One row of the directed table: either a register setting or a sample
    // beat, the latter optionally with its result typed in by hand.
    typedef struct {
        logic                 setup;
        logic [PIN_COUNT-1:0] levels;
        tick_t                tick;
        stamp_t               lo;
        stamp_t               hi;
        logic                 typed;
        result_t              want;
    } plan_row_t;

    plan_row_t plan [$];

    // ------------------------------------------------------------------------
    // Clock: 10 ns period.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: drop ready at random according to the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Capture model: advance one sample tick and return the result beat.
    // Edges are stamped with the timestamp as it stands on this tick; the
    // timestamp moves on by tick_us afterwards.
    // ------------------------------------------------------------------------
    function automatic result_t capture_tick(input logic [PIN_COUNT-1:0] lv);
        result_t              r;
        logic [PIN_COUNT-1:0] moved;
        stamp_t               span;
        r     = '0;
        moved = lv ^ prev_lv;
        for (int ch = 0; ch < ACTIVE_LANES; ch++)
        begin
            if (moved[ch])
            begin
                if (prev_lv[ch])
                begin
                    // A fall only closes a pulse whose rise was seen.
                    if (lane_high[ch])
                    begin
                        span          = now_st - rise_st[ch];
                        lane_high[ch] = 1'b0;
                        r.closed[ch]  = 1'b1;
                        if (span > cfg_min && span < cfg_max)
                        begin
                            held_w[ch]     = span;
                            r.accepted[ch] = 1'b1;
                        end
                    end
                end
                else
                begin
                    lane_high[ch] = 1'b1;
                    rise_st[ch]   = now_st;
                end
            end
        end
        prev_lv = lv;
        now_st  = now_st + stamp_t'(cfg_tick);
        for (int ch = 0; ch < PIN_COUNT; ch++)
            r.widths[ch] = (ch < ACTIVE_LANES) ? held_w[ch] : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders.
    // ------------------------------------------------------------------------
    function automatic void plan_sample(input logic [PIN_COUNT-1:0] lv);
        plan_row_t row;
        row        = '{default: '0};
        row.levels = lv;
        plan.push_back(row);
    endfunction

    // Sample beat whose result is typed in; only channels 0 and 1 ever hold
    // a width in these rows.
    function automatic void plan_typed(input logic [PIN_COUNT-1:0] lv,
                                       input stamp_t w0, input stamp_t w1,
                                       input logic [PIN_COUNT-1:0] closed,
                                       input logic [PIN_COUNT-1:0] acc);
        plan_row_t row;
        row               = '{default: '0};
        row.levels        = lv;
        row.typed         = 1'b1;
        row.want.widths   = {16'd0, 16'd0, 16'd0, 16'd0, w1, w0};
        row.want.closed   = closed;
        row.want.accepted = acc;
        plan.push_back(row);
    endfunction

    function automatic void plan_setup(input tick_t tk, input stamp_t lo, input stamp_t hi);
        plan_row_t row;
        row       = '{default: '0};
        row.setup = 1'b1;
        row.tick  = tk;
        row.lo    = lo;
        row.hi    = hi;
        plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: optionally idle, then present one sample beat and hold it until
    // accepted. Handshakes are sampled at the falling edge, where every
    // signal is settled, and take effect at the following rising edge.
    // ------------------------------------------------------------------------
    task automatic push_sample(input logic [PIN_COUNT-1:0] lv, input logic typed,
                               input result_t want);
        logic    took;
        result_t got;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        pin_levels <= lv;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        got = capture_tick(lv);
        pending_q.push_back(typed ? want : got);
    endtask

    // One register write beat; cfg_valid stays high so back-to-back writes
    // never lower and raise it within one time step.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        case (idx)
            CFG_TICK_US:   cfg_tick = data[TICK_W-1:0];
            CFG_MIN_WIDTH: cfg_min  = data;
            CFG_MAX_WIDTH: cfg_max  = data;
            default:       ;
        endcase
    endtask

    // Write every register; tick_us gets junk in its unused upper data bits.
    task automatic set_config(input tick_t tk, input stamp_t lo, input stamp_t hi);
        reg_write(NO_SUCH_REG, CFG_DATA_W'($urandom));
        reg_write(CFG_TICK_US, {8'($urandom), tk});
        reg_write(CFG_MIN_WIDTH, lo);
        reg_write(CFG_MAX_WIDTH, hi);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every pending result, then let the block settle.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string what, input logic [STAMP_W-1:0] want,
                                        input logic [STAMP_W-1:0] seen);
        if (seen !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected 'h%h actual 'h%h", $time, what, want, seen);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result beat with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    initial
    begin : result_check
        result_t seen;
        result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                seen.widths   = {width_ch5, width_ch4, width_ch3,
                                 width_ch2, width_ch1, width_ch0};
                seen.closed   = closed_mask;
                seen.accepted = accepted_mask;
                if (pending_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result beat, expected none %s 'h%h 'h%h",
                             $time, "actual closed/accepted", seen.closed, seen.accepted);
                end
                else
                begin
                    want = pending_q.pop_front();
                    for (int ch = 0; ch < PIN_COUNT; ch++)
                        check_field($sformatf("width_ch%0d", ch), want.widths[ch],
                                    seen.widths[ch]);
                    check_field("closed_mask", 16'(want.closed), 16'(seen.closed));
                    check_field("accepted_mask", 16'(want.accepted), 16'(seen.accepted));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on any channel for too long.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [PIN_COUNT-1:0] gen_lv;
        logic [PIN_COUNT-1:0] noisy;
        int                   hold_left [PIN_COUNT];
        int                   span_lo;
        int                   span_hi;
        int                   t;
        int                   lo;
        int                   hi;

        gen_lv = '0;
        for (int ch = 0; ch < PIN_COUNT; ch++)
        begin
            lane_high[ch] = 1'b0;
            rise_st[ch]   = '0;
            held_w[ch]    = '0;
        end

        // Hold reset, then release it for good.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Reset registers first: tick 8, bounds 1000..2000.
        plan_typed(6'h00, 16'd0, 16'd0, 6'h00, 6'h00);     // quiet pins after reset
        plan_typed(6'h3F, 16'd0, 16'd0, 6'h00, 6'h00);     // every channel rises
        plan_typed(6'h00, 16'd0, 16'd0, 6'h3F, 6'h00);     // 8 us pulses, below min
        // Largest tick, window 255..510 accepted, 765 sits on the upper bound.
        plan_setup(8'd255, 16'd254, 16'd765);
        plan_sample(6'h07);
        plan_typed(6'h06, 16'd255, 16'd0, 6'h01, 6'h01);
        plan_typed(6'h04, 16'd255, 16'd510, 6'h02, 6'h02);
        plan_typed(6'h00, 16'd255, 16'd510, 6'h04, 6'h00);
        // Zero tick: the timestamp stands still, so widths are zero and
        // fail even the widest bounds.
        plan_setup(8'd0, 16'd0, 16'd65535);
        plan_sample(6'h38);
        plan_typed(6'h00, 16'd255, 16'd510, 6'h38, 6'h00);
        // Bounds with no room between them: close pulses, accept nothing.
        plan_setup(8'd50, 16'd100, 16'd101);
        plan_sample(6'h3F);
        plan_sample(6'h3F);
        plan_typed(6'h00, 16'd255, 16'd510, 6'h3F, 6'h00);
        plan_sample(6'h2A);
        plan_sample(6'h15);                                 // falls and rises at once
        plan_sample(6'h00);
        // Smallest tick, a window just wide enough for 1 and 2 us.
        plan_setup(8'd1, 16'd0, 16'd3);
        plan_sample(6'h01);
        plan_sample(6'h03);
        plan_sample(6'h02);
        plan_sample(6'h00);

        foreach (plan[r])
        begin
            if (plan[r].setup)
            begin
                settle();
                set_config(plan[r].tick, plan[r].lo, plan[r].hi);
            end
            else
            begin
                push_sample(plan[r].levels, plan[r].typed, plan[r].want);
            end
        end

        // Random part: pulse trains sized around the acceptance window, with
        // the odd glitched or fully random sample mixed in.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: set_config(8'd255, 16'd0, 16'd65535);
                1: set_config(8'd1, 16'd65535, 16'd0);
                default:
                begin
                    t  = $urandom_range(255, 1);
                    lo = t * $urandom_range(12, 0) + $urandom_range(t, 0);
                    hi = lo + t * $urandom_range(12, 0) + $urandom_range(t, 0);
                    set_config(tick_t'(t), stamp_t'(lo), stamp_t'(hi));
                end
            endcase

            // Advance through the idle patterns: none, sender, receiver, both.
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase

            // Size high times so widths land below, inside and above bounds.
            if (cfg_tick == 0)
            begin
                span_lo = 1;
                span_hi = 8;
            end
            else
            begin
                span_lo = cfg_min / cfg_tick;
                span_hi = cfg_max / cfg_tick + 2;
            end
            if (span_lo > 28) span_lo = 28;
            if (span_lo < 1)  span_lo = 1;
            if (span_hi > 30) span_hi = 30;
            if (span_hi < span_lo) span_hi = span_lo;

            for (int ch = 0; ch < PIN_COUNT; ch++)
                hold_left[ch] = $urandom_range(5, 0);

            repeat (PHASE_BEATS)
            begin
                for (int ch = 0; ch < PIN_COUNT; ch++)
                begin
                    if (hold_left[ch] == 0)
                    begin
                        gen_lv[ch]    = ~gen_lv[ch];
                        hold_left[ch] = gen_lv[ch] ? $urandom_range(span_hi, span_lo)
                                                   : $urandom_range(6, 1);
                    end
                    hold_left[ch]--;
                end
                noisy = gen_lv;
                if ($urandom_range(7, 0) == 0)
                    noisy = noisy ^ (PIN_COUNT'(1) << $urandom_range(PIN_COUNT-1, 0));
                if ($urandom_range(31, 0) == 0)
                    noisy = PIN_COUNT'($urandom);
                push_sample(noisy, 1'b0, '0);
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();
        if (mismatches == 0 && pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/mpwc_pkg.sv
sv/mpwc_lane.sv
sv/mpwc_merge.sv
sv/multichannel_pulse_width_capture.sv
test/tb_multichannel_pulse_width_capture.sv
